@@ rtl/kth_word_unrank_assert.svh @@
// Assertion macros shared by the checker of the kth word unrank block.
`ifndef KTH_WORD_UNRANK_ASSERT_SVH
`define KTH_WORD_UNRANK_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define KWU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define KWU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kwu_pkg.sv @@
// Types and constants of the kth word unrank block.
package kwu_pkg;

  localparam int CntW   = 6;
  localparam int RankW  = 30;
  localparam int PathW  = 27;

  localparam logic [PathW-1:0] CountCap = 27'd100000001;

  typedef struct packed {
    logic [CntW-1:0]  count_a;
    logic [CntW-1:0]  count_b;
    logic [RankW-1:0] rank;
  } in_word_t;

  typedef struct packed {
    logic letter;
    logic none_found;
    logic last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_INIT_RD,
    ST_INIT_WR,
    ST_IDLE,
    ST_CHECK,
    ST_STEP
  } state_e;

endpackage

@@ rtl/kwu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module kwu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/kth_word_unrank.sv @@
// Top level of the kth word unrank block: path count table and letter sequencer.
//
// Input channel (in_valid_i / in_stall_o / in_word_i) takes a query: letter
// counts count_a, count_b and a one-based rank. Output channel (out_valid_o /
// out_stall_i / out_word_o) returns the word of that rank among all words of
// those letters in lexicographic order, one letter per word with last set on
// the final one, or a single word with none_found and last set.
// A word moves on a channel at a clock edge where valid is high and stall low.
//
// After reset the block sweeps the path count table, a read state and a write
// state per entry; in_stall_o stays high meanwhile. A query is then latched,
// one table read gives the total, and unless the result is none, one table
// read and compare follow per letter, the table's single read port setting
// that pace. One query is worked at a time; the next is taken once the final
// word sits in the output register. A stall on the output holds that register
// and the sequencer waits on it without losing a letter.
module kth_word_unrank #(
  parameter int MAX_A = 32,
  parameter int MAX_B = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kwu_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kwu_pkg::out_word_t out_word_o
);

  localparam int Depth = (MAX_A + 1) * (MAX_B + 1);
  localparam int AddrW = $clog2(Depth);
  localparam int IaW   = $clog2(MAX_A + 1);
  localparam int IbW   = $clog2(MAX_B + 1);
  localparam int PathW = kwu_pkg::PathW;
  localparam int CntW  = kwu_pkg::CntW;
  localparam int RankW = kwu_pkg::RankW;

  function automatic logic [AddrW-1:0] idx(input int a, input int b);
    return AddrW'(a * (MAX_B + 1) + b);
  endfunction

  kwu_pkg::state_e    state_q, state_d;
  logic [IaW-1:0]     ia_q, ia_d;
  logic [IbW-1:0]     ib_q, ib_d;
  logic [PathW-1:0]   left_q, left_d;
  logic [CntW-1:0]    na_q, na_d;
  logic [CntW-1:0]    nb_q, nb_d;
  logic [RankW-1:0]   k_q, k_d;
  logic               bad_q, bad_d;
  logic               out_valid_q, out_valid_d;
  kwu_pkg::out_word_t out_q, out_d;

  logic               we;
  logic [AddrW-1:0]   waddr;
  logic [PathW-1:0]   wdata;
  logic [AddrW-1:0]   raddr;
  logic [PathW-1:0]   rdata;
  logic [PathW:0]     sum;
  logic [RankW-1:0]   rdata_ext;
  logic               out_free;

  kwu_ram #(
    .Width(PathW),
    .Depth(Depth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign sum       = {1'b0, rdata} + {1'b0, left_q};
  assign rdata_ext = RankW'(rdata);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign waddr     = idx(int'(ia_q), int'(ib_q));

  always_comb begin
    state_d     = state_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    left_d      = left_q;
    na_d        = na_q;
    nb_d        = nb_q;
    k_d         = k_q;
    bad_d       = bad_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    wdata       = left_q;

    case (state_q)
      kwu_pkg::ST_INIT_RD: begin
        state_d = kwu_pkg::ST_INIT_WR;
      end
      kwu_pkg::ST_INIT_WR: begin
        we = 1'b1;
        if (ia_q == '0 || ib_q == '0) begin
          wdata = PathW'(1);
        end else if (sum > {1'b0, kwu_pkg::CountCap}) begin
          wdata = kwu_pkg::CountCap;
        end else begin
          wdata = sum[PathW-1:0];
        end
        left_d  = wdata;
        state_d = kwu_pkg::ST_INIT_RD;
        if (ib_q == IbW'(MAX_B)) begin
          ib_d = '0;
          if (ia_q == IaW'(MAX_A)) begin
            state_d = kwu_pkg::ST_IDLE;
          end else begin
            ia_d = ia_q + IaW'(1);
          end
        end else begin
          ib_d = ib_q + IbW'(1);
        end
      end
      kwu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          na_d    = in_word_i.count_a;
          nb_d    = in_word_i.count_b;
          k_d     = in_word_i.rank;
          bad_d   = (in_word_i.count_a == '0 && in_word_i.count_b == '0) ||
                    (int'(in_word_i.count_a) > MAX_A) ||
                    (int'(in_word_i.count_b) > MAX_B);
          state_d = kwu_pkg::ST_CHECK;
        end
      end
      kwu_pkg::ST_CHECK: begin
        if (bad_q || rdata_ext < k_q) begin
          if (out_free) begin
            out_valid_d      = 1'b1;
            out_d.letter     = 1'b0;
            out_d.none_found = 1'b1;
            out_d.last       = 1'b1;
            state_d          = kwu_pkg::ST_IDLE;
          end
        end else begin
          state_d = kwu_pkg::ST_STEP;
        end
      end
      kwu_pkg::ST_STEP: begin
        if (out_free) begin
          if (na_q == '0) begin
            out_d.letter = 1'b1;
            nb_d         = nb_q - CntW'(1);
          end else if (nb_q == '0) begin
            out_d.letter = 1'b0;
            na_d         = na_q - CntW'(1);
          end else if (rdata_ext >= k_q) begin
            out_d.letter = 1'b0;
            na_d         = na_q - CntW'(1);
          end else begin
            // take b: skip every word that starts with a
            out_d.letter = 1'b1;
            nb_d         = nb_q - CntW'(1);
            k_d          = k_q - rdata_ext;
          end
          out_valid_d      = 1'b1;
          out_d.none_found = 1'b0;
          out_d.last       = (na_d == '0) && (nb_d == '0);
          if (out_d.last) begin
            state_d = kwu_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = kwu_pkg::ST_IDLE;
      end
    endcase
  end

  // Address the table with next-cycle values so data lines up with the state.
  always_comb begin
    raddr = '0;
    case (state_d)
      kwu_pkg::ST_INIT_WR: begin
        if (ia_d != '0) begin
          raddr = idx(int'(ia_d) - 1, int'(ib_d));
        end
      end
      kwu_pkg::ST_CHECK: begin
        if (!bad_d) begin
          raddr = idx(int'(na_d), int'(nb_d));
        end
      end
      kwu_pkg::ST_STEP: begin
        if (na_d != '0 && nb_d != '0) begin
          raddr = idx(int'(na_d) - 1, int'(nb_d));
        end
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kwu_pkg::ST_INIT_RD;
      ia_q        <= '0;
      ib_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    na_q   <= na_d;
    nb_q   <= nb_d;
    k_q    <= k_d;
    bad_q  <= bad_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != kwu_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/kwu_checker.sv @@
// Port-level checker of the kth word unrank block, bound to the top level.
`include "kth_word_unrank_assert.svh"

module kwu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input kwu_pkg::out_word_t out_word_o
);

  logic in_acc;
  logic none_out;
  logic mid_out;
  logic out_held;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign none_out = out_valid_o && out_word_o.none_found;
  assign mid_out  = out_valid_o && !out_word_o.last;
  assign out_held = out_valid_o && out_stall_i;

  `KWU_ASSERT_NOW(a_none_is_last, none_out, out_word_o.last, "none word without last")
  `KWU_ASSERT_NOW(a_none_letter_zero, none_out, !out_word_o.letter, "none word with letter set")
  `KWU_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "query accepted while one runs")
  `KWU_ASSERT_NOW(a_busy_mid_word, mid_out, in_stall_o, "idle before last letter")
  `KWU_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_word_o), "stalled word moved")

endmodule

bind kth_word_unrank kwu_checker u_kwu_checker (.*);

@@ test/kth_word_unrank_tb.sv @@
// Self-checking testbench of the kth word unrank block: random and corner queries, checked letters.
module kth_word_unrank_tb;
  import kwu_pkg::*;

  localparam int MAX_A          = 32;
  localparam int MAX_B          = 32;
  localparam int RANDOM_QUERIES = 270;
  localparam int IDLE_PCT       = 28;
  localparam int TAIL_CYCLES    = 100;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_PRINTED    = 30;

  localparam logic LETTER_A = 1'b0;
  localparam logic LETTER_B = 1'b1;

  typedef struct {
    in_word_t word;
    bit       drain;
  } query_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  logic [PathW-1:0] word_count [0:MAX_A][0:MAX_B];
  query_t           pending[$];
  out_word_t        letters_due[$];

  int unsigned queries_total = 0;
  int unsigned queries_taken = 0;
  int unsigned letters_seen  = 0;
  int unsigned nones_seen    = 0;
  int unsigned errors        = 0;
  int unsigned cycles        = 0;
  logic        calm;

  // No idling at all for a long stretch in the middle of the random part.
  assign calm = (queries_taken >= 120) && (queries_taken < 180);

  kth_word_unrank #(
    .MAX_A(MAX_A),
    .MAX_B(MAX_B)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99, 0) < IDLE_PCT);
  endfunction

  // Number of words per letter-count pair, saturated at the cap.
  function automatic void fill_word_counts();
    logic [PathW:0] sum;
    for (int a = 0; a <= MAX_A; a++) begin
      for (int b = 0; b <= MAX_B; b++) begin
        if (a == 0 || b == 0) begin
          word_count[a][b] = 1;
        end else begin
          sum = word_count[a-1][b] + word_count[a][b-1];
          word_count[a][b] = (sum > CountCap) ? CountCap : sum[PathW-1:0];
        end
      end
    end
  endfunction

  // Walk the word of the given rank letter by letter.
  function automatic void expect_letters(in_word_t q);
    int unsigned      na;
    int unsigned      nb;
    logic [RankW-1:0] k;
    out_word_t        r;
    na = q.count_a;
    nb = q.count_b;
    k  = q.rank;
    if ((na == 0 && nb == 0) || na > MAX_A || nb > MAX_B || word_count[na][nb] < k) begin
      r.letter     = LETTER_A;
      r.none_found = 1'b1;
      r.last       = 1'b1;
      letters_due.push_back(r);
      return;
    end
    while (na != 0 || nb != 0) begin
      if (na != 0 && (nb == 0 || word_count[na-1][nb] >= k)) begin
        r.letter = LETTER_A;
        na--;
      end else begin
        // skip every word that still starts with a here
        if (na != 0) k = k - word_count[na-1][nb];
        r.letter = LETTER_B;
        nb--;
      end
      r.none_found = 1'b0;
      r.last       = (na == 0 && nb == 0);
      letters_due.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_letter(out_word_t got);
    out_word_t want;
    if (letters_due.size() == 0) begin
      report_mismatch($sformatf("unexpected word %b", got));
      return;
    end
    want = letters_due.pop_front();
    letters_seen++;
    if (want.none_found) nones_seen++;
    if (got.letter !== want.letter)
      report_mismatch($sformatf("letter %b, want %b", got.letter, want.letter));
    if (got.none_found !== want.none_found)
      report_mismatch($sformatf("none_found %b, want %b", got.none_found, want.none_found));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", got.last, want.last));
  endtask

  function automatic void add_query(int unsigned a, int unsigned b, logic [RankW-1:0] k,
                                    bit drain);
    query_t q;
    q.word.count_a = a[CntW-1:0];
    q.word.count_b = b[CntW-1:0];
    q.word.rank    = k;
    q.drain        = drain;
    pending.push_back(q);
    queries_total++;
  endfunction

  // Query driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expect_letters(in_word);
        queries_taken++;
      end
      if (!in_valid || !in_stall) begin
        // a drain query holds until every outstanding letter is back
        if (pending.size() != 0 && !(pending[0].drain && letters_due.size() != 0) &&
            !roll_idle()) begin
          in_word  <= pending[0].word;
          in_valid <= 1'b1;
          void'(pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Letter monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_letter(out_word);
      out_stall <= roll_idle();
    end
  end

  initial begin
    int unsigned      a;
    int unsigned      b;
    int unsigned      pick;
    logic [RankW-1:0] k;
    fill_word_counts();

    add_query(0, 0, 1, 1'b0);
    add_query(0, 0, 0, 1'b0);
    add_query(1, 0, 0, 1'b0);
    add_query(0, 1, 1, 1'b0);
    add_query(32, 32, 1, 1'b0);
    add_query(32, 32, 100000001, 1'b0);
    add_query(32, 32, 100000002, 1'b0);
    add_query(32, 32, 30'h3FFFFFFF, 1'b0);
    add_query(32, 32, 0, 1'b0);
    add_query(33, 1, 1, 1'b0);
    add_query(1, 33, 1, 1'b0);
    add_query(63, 63, 30'h3FFFFFFF, 1'b0);
    add_query(2, 2, 6, 1'b0);
    add_query(2, 2, 7, 1'b0);
    add_query(3, 2, 0, 1'b0);
    add_query(32, 0, 1, 1'b0);
    add_query(0, 32, 1, 1'b0);
    add_query(0, 32, 2, 1'b0);
    add_query(5, 5, 252, 1'b0);
    add_query(5, 5, 100, 1'b0);
    add_query(1, 31, 32, 1'b0);
    add_query(31, 1, 32, 1'b0);
    add_query(10, 12, 100000001, 1'b0);
    add_query(20, 20, 30'h2AAAAAAA, 1'b0);
    add_query(16, 16, 300540195 % 100000001, 1'b0);

    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 60) begin
        a = $urandom_range(10, 0);
        b = $urandom_range(10, 0);
      end else if (pick < 85) begin
        a = $urandom_range(MAX_A, 0);
        b = $urandom_range(MAX_B, 0);
      end else begin
        a = $urandom_range(63, 0);
        b = $urandom_range(63, 0);
      end
      if (pick >= 85 && pick < 92) k = $urandom();
      else if (a > MAX_A || b > MAX_B) k = $urandom_range(5, 0);
      else if (pick % 10 == 0) k = word_count[a][b] + 1;
      else if (pick % 10 == 1) k = 0;
      else k = $urandom_range(word_count[a][b], 1);
      add_query(a, b, k, (i % 60) == 0);
    end

    wait (rst_ni === 1'b1);
    while (queries_taken != queries_total || letters_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (letters_due.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", letters_due.size()));

    $display("covered %0d queries, %0d result words checked (%0d none), %0d cycles",
             queries_taken, letters_seen, nones_seen, cycles);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
